FILE: design/ret_pkg.sv
// ----------------------------------------------------------------------------
// ret_pkg: shared types and constants
// Payload structs, op and status codes, table geometry.
// ----------------------------------------------------------------------------
`default_nettype none
package ret_pkg;
  localparam int SOCKETS   = 1024;
  localparam int IDW       = 10;
  localparam int MAX_BATCH = 64;
  localparam logic [31:0] ERR_HUP_BITS = 32'h0000_0018;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_DEL     = 3'd1;
  localparam logic [2:0] OP_MOD     = 3'd2;
  localparam logic [2:0] OP_EVENT   = 3'd3;
  localparam logic [2:0] OP_COLLECT = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_MERGED   = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  sock_id;
    logic [31:0] event_mask;
    logic [63:0] user_data;
    logic [6:0]  max_events;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ready_mask;
    logic [63:0] ready_data;
    logic [6:0]  collected;
    logic        last;
  } out_item_t;

  // classified command passed front to back
  typedef struct packed {
    logic        invalid;
    logic [2:0]  op;
    logic [9:0]  id;
    logic [31:0] mask;
    logic [63:0] data;
    logic [6:0]  num_max;
  } cmd_t;
endpackage
`default_nettype wire

FILE: design/readiness_event_table_top.sv
// ----------------------------------------------------------------------------
// readiness_event_table_top: interest table with ready list
// Socket-keyed table of mask and data, with a most-recent-first ready list.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken when start is high and busy is low.
//   busy rises only while the two-entry command queue is full.
//   Output: each result shows for one cycle with out_valid; the receiver
//   cannot stall, so no hold is needed.
//   Add, delete, modify and event raise out_valid after the queue pop and
//   then the table read-modify-write; the engine pops the next command only
//   once it is back in idle, while the queue keeps taking input.
//   Collect walks the ready list entry by entry (read head, then unlink),
//   so n entries give n results.
//   Reset: a clearing pass over every socket wipes the valid and ready bits;
//   commands queue during it and run once it is done.
// ----------------------------------------------------------------------------
`default_nettype none
module readiness_event_table_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ret_pkg::in_item_t in_item,
  output logic                   out_valid,
  output ret_pkg::out_item_t     out_item
);
  logic          pop, cmd_valid;
  ret_pkg::cmd_t cmd;

  ret_front u_front (.clk, .rst_n, .start, .busy, .in_item, .pop, .cmd_valid, .cmd);
  ret_back  u_back  (.clk, .rst_n, .cmd_valid, .cmd, .pop, .out_valid, .out_item);
endmodule
`default_nettype wire

FILE: design/ret_front.sv
// ----------------------------------------------------------------------------
// ret_front: command intake
// Checks op and a zero max_events on collect, clamps max_events, pushes a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module ret_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ret_pkg::in_item_t in_item,
  input  wire logic              pop,
  output logic                   cmd_valid,
  output ret_pkg::cmd_t          cmd
);
  ret_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  ret_pkg::cmd_t c;
  logic push;

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    c.op      = in_item.op;
    c.id      = in_item.sock_id;
    c.mask    = in_item.event_mask;
    c.data    = in_item.user_data;
    c.num_max = (in_item.max_events > 7'(ret_pkg::MAX_BATCH)) ?
                7'(ret_pkg::MAX_BATCH) : in_item.max_events;
    if (in_item.op == ret_pkg::OP_COLLECT) c.invalid = (in_item.max_events == 7'd0);
    else c.invalid = (in_item.op > ret_pkg::OP_COLLECT);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
    end
  end
endmodule
`default_nettype wire

FILE: design/ret_back.sv
// ----------------------------------------------------------------------------
// ret_back: table engine
// Memory read-modify-write per command; collect walks the ready list.
// ----------------------------------------------------------------------------
`default_nettype none
module ret_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire ret_pkg::cmd_t cmd,
  output logic               pop,
  output logic               out_valid,
  output ret_pkg::out_item_t out_item
);
  localparam logic [1:0] S_IDLE = 2'd0, S_EXEC = 2'd1, S_CLR = 2'd2, S_WALK = 2'd3;

  logic [31:0] mask_m [ret_pkg::SOCKETS];
  logic [63:0] data_m [ret_pkg::SOCKETS];
  logic [9:0]  next_m [ret_pkg::SOCKETS];
  logic [9:0]  prev_m [ret_pkg::SOCKETS];
  logic        vld_m  [ret_pkg::SOCKETS];
  logic        rdy_m  [ret_pkg::SOCKETS];

  logic [1:0]  st_r;
  logic [9:0]  clr_r;
  ret_pkg::cmd_t c_r;
  logic [9:0]  head_r, tail_r;
  logic [10:0] rcnt_r;
  logic [6:0]  num_r, k_r;
  logic [31:0] rm_r; logic [63:0] rd_r; logic [9:0] rn_r, rp_r;
  logic rv_r, rr_r;
  logic [9:0] a;

  // read address: command id, or current head when walking
  assign a   = (st_r == S_WALK) ? head_r : cmd.id;
  assign pop = (st_r == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    rm_r <= mask_m[a]; rd_r <= data_m[a]; rn_r <= next_m[a]; rp_r <= prev_m[a];
    rv_r <= vld_m[a];  rr_r <= rdy_m[a];
    out_valid <= 1'b0;
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; head_r <= '0; tail_r <= '0; rcnt_r <= '0;
    end else begin
      case (st_r)
        S_CLR: begin
          vld_m[clr_r] <= 1'b0; rdy_m[clr_r] <= 1'b0;
          clr_r <= clr_r + 10'd1;
          if (clr_r == 10'(ret_pkg::SOCKETS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (cmd_valid) begin
          c_r <= cmd; st_r <= S_EXEC;
        end
        S_EXEC: begin
          st_r <= S_IDLE;
          out_valid <= 1'b1;
          out_item <= '{status: ret_pkg::ST_OK, ready_mask: '0, ready_data: '0,
                        collected: '0, last: 1'b1};
          if (c_r.invalid) out_item.status <= ret_pkg::ST_INVALID;
          else case (c_r.op)
            ret_pkg::OP_ADD:
              if (rv_r) out_item.status <= ret_pkg::ST_PRESENT;
              else begin
                vld_m[c_r.id] <= 1'b1; rdy_m[c_r.id] <= 1'b0;
                mask_m[c_r.id] <= c_r.mask; data_m[c_r.id] <= c_r.data;
              end
            ret_pkg::OP_DEL:
              if (!rv_r) out_item.status <= ret_pkg::ST_NOTFOUND;
              else begin
                vld_m[c_r.id] <= 1'b0;
                if (rr_r) begin
                  rdy_m[c_r.id] <= 1'b0;
                  if (c_r.id == head_r) head_r <= rn_r; else next_m[rp_r] <= rn_r;
                  if (c_r.id == tail_r) tail_r <= rp_r; else prev_m[rn_r] <= rp_r;
                  rcnt_r <= rcnt_r - 11'd1;
                end
              end
            ret_pkg::OP_MOD:
              if (!rv_r) out_item.status <= ret_pkg::ST_NOTFOUND;
              else mask_m[c_r.id] <= c_r.mask | ret_pkg::ERR_HUP_BITS;
            ret_pkg::OP_EVENT:
              if (!rv_r) out_item.status <= ret_pkg::ST_NOTFOUND;
              else if (rr_r) begin
                mask_m[c_r.id] <= rm_r | c_r.mask;
                out_item.status <= ret_pkg::ST_MERGED;
              end else begin
                rdy_m[c_r.id] <= 1'b1;
                if (rcnt_r == 11'd0) tail_r <= c_r.id; else prev_m[head_r] <= c_r.id;
                next_m[c_r.id] <= head_r; prev_m[c_r.id] <= c_r.id;
                head_r <= c_r.id; rcnt_r <= rcnt_r + 11'd1;
              end
            ret_pkg::OP_COLLECT:
              if (rcnt_r != 11'd0) begin
                out_valid <= 1'b0;
                num_r <= (rcnt_r < 11'(c_r.num_max)) ? rcnt_r[6:0] : c_r.num_max;
                k_r <= 7'd0;
                st_r <= S_WALK;
              end
            default: out_item.status <= ret_pkg::ST_INVALID;
          endcase
        end
        S_WALK: begin
          // read then unlink phases: phase bit in c_r.invalid (free during walk)
          c_r.invalid <= !c_r.invalid;
          if (c_r.invalid) begin
            out_valid <= 1'b1;
            out_item <= '{status: ret_pkg::ST_OK, ready_mask: rm_r, ready_data: rd_r,
                          collected: k_r + 7'd1, last: (k_r + 7'd1 == num_r)};
            rdy_m[head_r] <= 1'b0;
            if (head_r == tail_r) tail_r <= rp_r; else prev_m[rn_r] <= rp_r;
            head_r <= rn_r;
            rcnt_r <= rcnt_r - 11'd1;
            k_r <= k_r + 7'd1;
            if (k_r + 7'd1 == num_r) st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
